@@ hdl/csf_pkg.sv @@
`default_nettype none

package csf_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned HDR_LEN  = 16;
   localparam int unsigned HCNT_W   = $clog2(HDR_LEN);
   localparam int unsigned HOLD_W   = (HDR_LEN - 1) * BYTE_W;
   localparam int unsigned IDX_W    = 2;
   localparam int unsigned STAT_W   = 2;
   localparam int unsigned USER_W   = 1 + STAT_W;

   localparam logic [IDX_W-1:0] REG_CHUNK_MAGIC    = 2'd0;
   localparam logic [IDX_W-1:0] REG_STREAM_UID     = 2'd1;
   localparam logic [IDX_W-1:0] REG_LAST_FLAG_MASK = 2'd2;

   localparam logic [WORD_W-1:0] LAST_FLAG_MASK_RST = 32'h0000_0001;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_FORWARD = 2'd1,
      PH_DROP    = 2'd2,
      PH_ENDED   = 2'd3
   } phase_type;

   typedef enum logic [STAT_W-1:0] {
      ST_RUNNING   = 2'd0,
      ST_COMPLETED = 2'd1,
      ST_EARLY_END = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] chunk_magic;
      logic [WORD_W-1:0] stream_uid;
      logic [WORD_W-1:0] last_flag_mask;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/chunk_stream_filter_unit.sv @@
// Chunk stream filter: takes a container file one byte per word on req_ and
// forwards on rsp_ only the payload bytes of chunks whose 16-byte big-endian
// header (magic, flags, size, uid) matches chunk_magic and stream_uid. Every
// accepted word yields exactly one result word in the cycle after it; a word with
// req_tlast set marks end of file. Status in rsp_tuser reads running, last
// chunk completed, or file ended early; after the end all words return the
// final status with no data. Throughput is one byte per cycle unless rsp_tready
// stalls the output; header compare and the payload down-counter settle
// combinationally between the chunk state registers and the result register;
// while a result waits, req_tready follows rsp_tready combinationally.
// Configuration writes take effect at the next completed header.

`default_nettype none

module chunk_stream_filter_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [csf_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [csf_pkg::WORD_W-1:0] csr_wdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [csf_pkg::BYTE_W-1:0] req_tdata,   // [7:0] file_byte
   input  wire logic                       req_tlast,   // end_of_file
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [csf_pkg::BYTE_W-1:0]      rsp_tdata,   // [7:0] payload_byte
   output logic [csf_pkg::USER_W-1:0]      rsp_tuser    // [0] payload_valid, [2:1] stream_status
);
   import csf_pkg::*;

   cfg_type cfg;

   csf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ hdl/csf_csr.sv @@
`default_nettype none

module csf_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [csf_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [csf_pkg::WORD_W-1:0] csr_wdata,
   output csf_pkg::cfg_type                cfg
);
   import csf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_CHUNK_MAGIC:    cfg_in.chunk_magic    = csr_wdata;
            REG_STREAM_UID:     cfg_in.stream_uid     = csr_wdata;
            REG_LAST_FLAG_MASK: cfg_in.last_flag_mask = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_magic    <= '0;
         cfg_ff.stream_uid     <= '0;
         cfg_ff.last_flag_mask <= LAST_FLAG_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/csf_parser.sv @@
`default_nettype none

module csf_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire csf_pkg::cfg_type           cfg,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [csf_pkg::BYTE_W-1:0] req_tdata,
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [csf_pkg::BYTE_W-1:0]      rsp_tdata,
   output logic [csf_pkg::USER_W-1:0]      rsp_tuser
);
   import csf_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [HCNT_W-1:0]     hcnt_ff, hcnt_in;
   logic [HOLD_W-1:0]     hdr_ff, hdr_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic                  last_ff, last_in;

   logic                  ovalid_ff;
   logic [BYTE_W-1:0]     odata_ff, odata_in;
   logic [USER_W-1:0]     ouser_ff, ouser_in;

   logic [HOLD_W+BYTE_W-1:0] hdr_full;
   logic [WORD_W-1:0]        h_magic, h_flags, h_size, h_uid;
   logic                     match;
   logic                     accept;
   logic                     out_vld;
   status_type               status;

   assign req_tready = !ovalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign hdr_full = {hdr_ff, req_tdata};
   assign h_magic  = hdr_full[4*WORD_W-1:3*WORD_W];
   assign h_flags  = hdr_full[3*WORD_W-1:2*WORD_W];
   assign h_size   = hdr_full[2*WORD_W-1:WORD_W];
   assign h_uid    = hdr_full[WORD_W-1:0];
   assign match    = (h_magic == cfg.chunk_magic) && (h_uid == cfg.stream_uid);

   always_comb begin
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      hdr_in   = hdr_ff;
      rem_in   = rem_ff;
      last_in  = last_ff;
      odata_in = '0;
      out_vld  = 1'b0;
      if (phase_ff != PH_ENDED) begin
         if (req_tlast) begin
            phase_in = PH_ENDED;
            last_in  = 1'b0;
         end else if (phase_ff == PH_HEADER) begin
            hdr_in  = hdr_full[HOLD_W-1:0];
            hcnt_in = hcnt_ff + 1'b1;
            if (hcnt_ff == HCNT_W'(HDR_LEN - 1)) begin
               rem_in = h_size;
               if (match) begin
                  last_in  = (h_flags & cfg.last_flag_mask) != '0;
                  phase_in = PH_FORWARD;
               end else begin
                  phase_in = PH_DROP;
               end
               if (h_size == '0) begin
                  phase_in = (match && last_in) ? PH_ENDED : PH_HEADER;
               end
            end
         end else begin
            if (phase_ff == PH_FORWARD) begin
               odata_in = req_tdata;
               out_vld  = 1'b1;
            end
            rem_in = rem_ff - 1'b1;
            if (rem_ff == WORD_W'(1)) begin
               phase_in = (phase_ff == PH_FORWARD && last_ff) ? PH_ENDED : PH_HEADER;
            end
         end
      end
      if (phase_in == PH_ENDED) begin
         status = last_in ? ST_COMPLETED : ST_EARLY_END;
      end else begin
         status = ST_RUNNING;
      end
      ouser_in = {status, out_vld};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hcnt_ff   <= '0;
         rem_ff    <= '0;
         last_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            hcnt_ff  <= hcnt_in;
            rem_ff   <= rem_in;
            last_ff  <= last_in;
         end
         if (req_tready) begin
            ovalid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff   <= hdr_in;
         odata_ff <= odata_in;
         ouser_ff <= ouser_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;

endmodule

`default_nettype wire
